@@ hw/rtl/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEF_QUEUE_DEPTH   = 16;
  localparam int DEF_PRIORITY_BITS = 8;

  localparam int DATA_W      = 32;
  localparam int PRIO_PORT_W = 8;
  localparam int FILL_W      = 5;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctrl_t;

endpackage

@@ hw/rtl/spq_cell.sv @@
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain. On an insert it keeps its entry, takes the
// new entry or takes its left neighbor's entry; on a remove it takes its
// right neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell #(
  parameter int PRIORITY_BITS = spq_pkg::DEF_PRIORITY_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  spq_pkg::cell_ctrl_t        ctrl,
  input  logic [spq_pkg::DATA_W-1:0] new_data,
  input  logic [PRIORITY_BITS-1:0]   new_prio,
  input  logic                       left_valid,
  input  logic                       left_keep,
  input  logic [spq_pkg::DATA_W-1:0] left_data,
  input  logic [PRIORITY_BITS-1:0]   left_prio,
  input  logic                       right_valid,
  input  logic [spq_pkg::DATA_W-1:0] right_data,
  input  logic [PRIORITY_BITS-1:0]   right_prio,
  output logic                       valid,
  output logic [spq_pkg::DATA_W-1:0] data,
  output logic [PRIORITY_BITS-1:0]   prio,
  output logic                       keep
);
  import spq_pkg::*;

  logic                     valid_r, valid_nxt;
  logic [DATA_W-1:0]        data_r, data_nxt;
  logic [PRIORITY_BITS-1:0] prio_r, prio_nxt;

  assign keep  = valid_r && (prio_r <= new_prio);
  assign valid = valid_r;
  assign data  = data_r;
  assign prio  = prio_r;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    prio_nxt  = prio_r;
    if (ctrl.ins) begin
      if (!keep) begin
        if (left_keep) begin
          valid_nxt = 1'b1;
          data_nxt  = new_data;
          prio_nxt  = new_prio;
        end else begin
          valid_nxt = left_valid;
          data_nxt  = left_data;
          prio_nxt  = left_prio;
        end
      end
    end else if (ctrl.rem) begin
      valid_nxt = right_valid;
      data_nxt  = right_data;
      prio_nxt  = right_prio;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    data_r <= data_nxt;
    prio_r <= prio_nxt;
  end

endmodule

@@ hw/rtl/sorted_priority_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue held as a sorted chain of cells.
// ----------------------------------------------------------------------------
// Each input beat is an insert or a remove and yields exactly one result beat.
// Every cell compares the new priority against its own in the same cycle, so
// an operation completes in that same cycle and a new beat is taken every
// cycle while the output register is free or being drained; the output
// register is the only stage between the two channels. A lower priority value
// is served first and equal priorities leave in arrival order. A remove from
// an empty queue reports an empty status, and an insert into a full queue is
// dropped with a full status. No clearing pass is needed after reset.
module sorted_priority_queue #(
  parameter int QUEUE_DEPTH   = spq_pkg::DEF_QUEUE_DEPTH,
  parameter int PRIORITY_BITS = spq_pkg::DEF_PRIORITY_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_op,
  input  logic signed [spq_pkg::DATA_W-1:0] in_item_data,
  input  logic [spq_pkg::PRIO_PORT_W-1:0]   in_item_priority,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [spq_pkg::DATA_W-1:0] out_data,
  output logic [spq_pkg::PRIO_PORT_W-1:0]   out_priority,
  output logic [1:0]                        out_status,
  output logic [spq_pkg::FILL_W-1:0]        out_fill_count
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  logic [CNT_W-1:0]         count_r, count_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]        out_data_r, out_data_nxt;
  logic [PRIO_PORT_W-1:0]   out_prio_r, out_prio_nxt;
  status_t                  out_status_r, out_status_nxt;
  logic [CNT_W-1:0]         out_fill_r, out_fill_nxt;

  logic                     in_fire;
  cell_ctrl_t               ctrl;
  logic [PRIORITY_BITS-1:0] new_prio;

  logic                     cell_valid [QUEUE_DEPTH];
  logic                     cell_keep  [QUEUE_DEPTH];
  logic [DATA_W-1:0]        cell_data  [QUEUE_DEPTH];
  logic [PRIORITY_BITS-1:0] cell_prio  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]   valid_vec;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign new_prio = PRIORITY_BITS'(in_item_priority);

  assign ctrl.ins = in_fire && (in_op == OP_INSERT) && (count_r != CNT_FULL);
  assign ctrl.rem = in_fire && (in_op == OP_REMOVE) && (count_r != '0);

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                     l_valid, l_keep, r_valid;
    logic [DATA_W-1:0]        l_data, r_data;
    logic [PRIORITY_BITS-1:0] l_prio, r_prio;

    if (i == 0) begin : g_head
      assign l_valid = 1'b0;
      assign l_keep  = 1'b1;
      assign l_data  = '0;
      assign l_prio  = '0;
    end else begin : g_body
      assign l_valid = cell_valid[i-1];
      assign l_keep  = cell_keep[i-1];
      assign l_data  = cell_data[i-1];
      assign l_prio  = cell_prio[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_data  = '0;
      assign r_prio  = '0;
    end else begin : g_inner
      assign r_valid = cell_valid[i+1];
      assign r_data  = cell_data[i+1];
      assign r_prio  = cell_prio[i+1];
    end

    spq_cell #(
      .PRIORITY_BITS(PRIORITY_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .new_data   (in_item_data),
      .new_prio   (new_prio),
      .left_valid (l_valid),
      .left_keep  (l_keep),
      .left_data  (l_data),
      .left_prio  (l_prio),
      .right_valid(r_valid),
      .right_data (r_data),
      .right_prio (r_prio),
      .valid      (cell_valid[i]),
      .data       (cell_data[i]),
      .prio       (cell_prio[i]),
      .keep       (cell_keep[i])
    );

    assign valid_vec[i] = cell_valid[i];
  end

  always_comb begin
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_prio_nxt   = out_prio_r;
    out_status_nxt = out_status_r;
    out_fill_nxt   = out_fill_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire) begin
      out_valid_nxt  = 1'b1;
      out_data_nxt   = '0;
      out_prio_nxt   = '0;
      out_status_nxt = ST_OK;
      if (in_op == OP_INSERT) begin
        if (count_r == CNT_FULL) begin
          out_status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end else begin
        if (count_r == '0) begin
          out_status_nxt = ST_EMPTY;
        end else begin
          count_nxt    = count_r - CNT_W'(1);
          out_data_nxt = cell_data[0];
          out_prio_nxt = PRIO_PORT_W'(cell_prio[0]);
        end
      end
      out_fill_nxt = count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r   <= out_data_nxt;
    out_prio_r   <= out_prio_nxt;
    out_status_r <= out_status_nxt;
    out_fill_r   <= out_fill_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_data       = out_data_r;
  assign out_priority   = out_prio_r;
  assign out_status     = out_status_r;
  assign out_fill_count = FILL_W'(out_fill_r);

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("Entry count exceeds the queue depth.");

  a_valid_matches_count : assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == int'(count_r))
    else $error("Occupied cells disagree with the entry count.");

  a_head_valid : assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) |-> cell_valid[0])
    else $error("Front cell is empty while the queue holds entries.");

  a_result_follows : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (out_valid_r && (out_fill_r == $past(count_nxt))))
    else $error("Result beat missing or with a wrong fill count.");

endmodule
